@@ rtl/core/ordlt_pkg.sv @@
// Package for the ordered list table: transfer payload structs, operation and
// status codes, controller states and the controller/datapath command and condition structs.
// Depends on nothing; every other file of the block uses it.
package ordlt_pkg;

  localparam int unsigned VALUE_W = 64;
  localparam int unsigned POS_W   = 7;
  localparam int unsigned INDEX_W = 6;
  localparam int unsigned COUNT_W = 7;

  typedef enum logic [2:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_READ   = 3'd2,
    OP_WRITE  = 3'd3,
    OP_REMOVE = 3'd4,
    OP_FIND   = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]         operation;
    logic [POS_W-1:0]   position;
    logic [VALUE_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [VALUE_W-1:0] read_value;
    logic [INDEX_W-1:0] result_index;
    logic [COUNT_W-1:0] entry_count;
    logic [1:0]         status;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_INS_RD,
    S_INS_WR,
    S_REM_RD,
    S_REM_WR,
    S_FIND_RD,
    S_FIND_CMP,
    S_RD_WAIT,
    S_DONE
  } state_e;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_COUNT,
    PTR_POS,
    PTR_ZERO,
    PTR_INC,
    PTR_DEC
  } ptr_op_e;

  typedef enum logic [1:0] {
    RA_POS,
    RA_PTR,
    RA_PTR_DN,
    RA_PTR_UP
  } rd_addr_e;

  typedef enum logic [1:0] {
    WA_POS,
    WA_PTR,
    WA_COUNT
  } wr_addr_e;

  typedef enum logic [1:0] {
    IDX_HOLD,
    IDX_COUNT,
    IDX_PTR
  } idx_op_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     capture;
    ptr_op_e  ptr_op;
    logic     mem_rd;
    rd_addr_e rd_addr;
    logic     mem_wr;
    wr_addr_e wr_addr;
    logic     wr_from_mem;
    logic     count_inc;
    logic     count_dec;
    logic     set_status;
    status_e  status;
    idx_op_e  idx_op;
    logic     load_read;
    logic     out_load;
  } dp_ctrl_t;

  // Conditions from the datapath to the controller.
  typedef struct packed {
    logic [2:0] operation;
    logic       full;
    logic       pos_le_count;
    logic       pos_lt_count;
    logic       ptr_gt_pos;
    logic       ptr_lt_count;
    logic       ptr_up_lt_count;
    logic       match;
    logic       out_free;
  } dp_stat_t;

endpackage

@@ rtl/core/ordered_list_table.sv @@
// Ordered list table: an ordered list of up to CAPACITY 64-bit words.
// Channels: cmd (operation, position, value) in, rsp (read_value,
// result_index, entry_count, status) out, both valid/ready; a transfer
// happens on a clock edge with valid and ready high. One response per
// command, in command order.
// The block works on one command at a time; its entry memory has a read
// address and a write address. Shifting and searching go through that
// memory one entry at a time: insert moves each entry from p up by one,
// starting at the top, remove moves each entry above p down by one, and
// find compares entries from index 0 up to the first match.
// cmd_ready rises again the cycle after the response is loaded, so the next
// command may be accepted while a response still waits in the output
// register. If the receiver stalls with a response pending, the next
// command finishes its work and then holds until the register frees.
// Synchronous reset empties the list; no clearing pass is needed since the
// count bounds every read. Depends on ordlt_pkg, ordlt_ctrl and ordlt_dp.
module ordered_list_table #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  ordlt_pkg::cmd_t cmd,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output ordlt_pkg::rsp_t rsp
);

  ordlt_pkg::dp_ctrl_t ctrl;
  ordlt_pkg::dp_stat_t stat;

  ordlt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  ordlt_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .ctrl      (ctrl),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

@@ rtl/core/ordlt_ctrl.sv @@
// Controller of the ordered list table: sequences each operation as steps
// on the datapath. Uses ordlt_pkg for states and command/status structs.
module ordlt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  ordlt_pkg::dp_stat_t stat,
  output ordlt_pkg::dp_ctrl_t ctrl
);

  ordlt_pkg::state_e state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ordlt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ordlt_pkg::S_IDLE: begin
        if (cmd_valid) state_next = ordlt_pkg::S_DECODE;
      end
      ordlt_pkg::S_DECODE: begin
        unique case (stat.operation)
          ordlt_pkg::OP_INSERT: begin
            if (stat.pos_le_count && !stat.full) state_next = ordlt_pkg::S_INS_RD;
            else state_next = ordlt_pkg::S_DONE;
          end
          ordlt_pkg::OP_READ: begin
            if (stat.pos_lt_count) state_next = ordlt_pkg::S_RD_WAIT;
            else state_next = ordlt_pkg::S_DONE;
          end
          ordlt_pkg::OP_REMOVE: begin
            if (stat.pos_lt_count) state_next = ordlt_pkg::S_REM_RD;
            else state_next = ordlt_pkg::S_DONE;
          end
          ordlt_pkg::OP_FIND: state_next = ordlt_pkg::S_FIND_RD;
          default: state_next = ordlt_pkg::S_DONE;
        endcase
      end
      ordlt_pkg::S_INS_RD: begin
        if (stat.ptr_gt_pos) state_next = ordlt_pkg::S_INS_WR;
        else state_next = ordlt_pkg::S_DONE;
      end
      ordlt_pkg::S_INS_WR: state_next = ordlt_pkg::S_INS_RD;
      ordlt_pkg::S_REM_RD: begin
        if (stat.ptr_up_lt_count) state_next = ordlt_pkg::S_REM_WR;
        else state_next = ordlt_pkg::S_DONE;
      end
      ordlt_pkg::S_REM_WR: state_next = ordlt_pkg::S_REM_RD;
      ordlt_pkg::S_FIND_RD: begin
        if (stat.ptr_lt_count) state_next = ordlt_pkg::S_FIND_CMP;
        else state_next = ordlt_pkg::S_DONE;
      end
      ordlt_pkg::S_FIND_CMP: begin
        if (stat.match) state_next = ordlt_pkg::S_DONE;
        else state_next = ordlt_pkg::S_FIND_RD;
      end
      ordlt_pkg::S_RD_WAIT: state_next = ordlt_pkg::S_DONE;
      ordlt_pkg::S_DONE: begin
        if (stat.out_free) state_next = ordlt_pkg::S_IDLE;
      end
      default: state_next = ordlt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready = 1'b0;
    ctrl      = '0;
    unique case (state)
      ordlt_pkg::S_IDLE: begin
        cmd_ready    = 1'b1;
        ctrl.capture = cmd_valid;
      end
      ordlt_pkg::S_DECODE: begin
        unique case (stat.operation)
          ordlt_pkg::OP_APPEND: begin
            if (stat.full) begin
              ctrl.set_status = 1'b1;
              ctrl.status     = ordlt_pkg::ST_FULL;
            end else begin
              ctrl.mem_wr    = 1'b1;
              ctrl.wr_addr   = ordlt_pkg::WA_COUNT;
              ctrl.idx_op    = ordlt_pkg::IDX_COUNT;
              ctrl.count_inc = 1'b1;
            end
          end
          ordlt_pkg::OP_INSERT: begin
            // The position is checked before fullness.
            if (!stat.pos_le_count) begin
              ctrl.set_status = 1'b1;
              ctrl.status     = ordlt_pkg::ST_RANGE;
            end else if (stat.full) begin
              ctrl.set_status = 1'b1;
              ctrl.status     = ordlt_pkg::ST_FULL;
            end else begin
              ctrl.ptr_op = ordlt_pkg::PTR_COUNT;
            end
          end
          ordlt_pkg::OP_READ: begin
            if (stat.pos_lt_count) begin
              ctrl.mem_rd  = 1'b1;
              ctrl.rd_addr = ordlt_pkg::RA_POS;
            end else begin
              ctrl.set_status = 1'b1;
              ctrl.status     = ordlt_pkg::ST_RANGE;
            end
          end
          ordlt_pkg::OP_WRITE: begin
            if (stat.pos_lt_count) begin
              ctrl.mem_wr  = 1'b1;
              ctrl.wr_addr = ordlt_pkg::WA_POS;
            end else begin
              ctrl.set_status = 1'b1;
              ctrl.status     = ordlt_pkg::ST_RANGE;
            end
          end
          ordlt_pkg::OP_REMOVE: begin
            if (stat.pos_lt_count) begin
              ctrl.ptr_op = ordlt_pkg::PTR_POS;
            end else begin
              ctrl.set_status = 1'b1;
              ctrl.status     = ordlt_pkg::ST_RANGE;
            end
          end
          ordlt_pkg::OP_FIND: begin
            ctrl.ptr_op     = ordlt_pkg::PTR_ZERO;
            ctrl.set_status = 1'b1;
            ctrl.status     = ordlt_pkg::ST_NOTFOUND;
          end
          default: ;
        endcase
      end
      ordlt_pkg::S_INS_RD: begin
        if (stat.ptr_gt_pos) begin
          ctrl.mem_rd  = 1'b1;
          ctrl.rd_addr = ordlt_pkg::RA_PTR_DN;
        end else begin
          // Gap is open at the position: drop the new word in.
          ctrl.mem_wr    = 1'b1;
          ctrl.wr_addr   = ordlt_pkg::WA_POS;
          ctrl.count_inc = 1'b1;
        end
      end
      ordlt_pkg::S_INS_WR: begin
        ctrl.mem_wr      = 1'b1;
        ctrl.wr_addr     = ordlt_pkg::WA_PTR;
        ctrl.wr_from_mem = 1'b1;
        ctrl.ptr_op      = ordlt_pkg::PTR_DEC;
      end
      ordlt_pkg::S_REM_RD: begin
        if (stat.ptr_up_lt_count) begin
          ctrl.mem_rd  = 1'b1;
          ctrl.rd_addr = ordlt_pkg::RA_PTR_UP;
        end else begin
          ctrl.count_dec = 1'b1;
        end
      end
      ordlt_pkg::S_REM_WR: begin
        ctrl.mem_wr      = 1'b1;
        ctrl.wr_addr     = ordlt_pkg::WA_PTR;
        ctrl.wr_from_mem = 1'b1;
        ctrl.ptr_op      = ordlt_pkg::PTR_INC;
      end
      ordlt_pkg::S_FIND_RD: begin
        if (stat.ptr_lt_count) begin
          ctrl.mem_rd  = 1'b1;
          ctrl.rd_addr = ordlt_pkg::RA_PTR;
        end
      end
      ordlt_pkg::S_FIND_CMP: begin
        if (stat.match) begin
          ctrl.set_status = 1'b1;
          ctrl.status     = ordlt_pkg::ST_OK;
          ctrl.idx_op     = ordlt_pkg::IDX_PTR;
        end else begin
          ctrl.ptr_op = ordlt_pkg::PTR_INC;
        end
      end
      ordlt_pkg::S_RD_WAIT: ctrl.load_read = 1'b1;
      ordlt_pkg::S_DONE: ctrl.out_load = stat.out_free;
      default: ;
    endcase
  end

endmodule

@@ rtl/core/ordlt_dp.sv @@
// Datapath of the ordered list table: entry memory, count, sweep pointer,
// result fields and the response register. Uses ordlt_pkg.
module ordlt_dp #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  ordlt_pkg::cmd_t     cmd,
  input  ordlt_pkg::dp_ctrl_t ctrl,
  output ordlt_pkg::dp_stat_t stat,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output ordlt_pkg::rsp_t     rsp
);

  localparam int unsigned ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W  = (CNT_W > ordlt_pkg::POS_W) ? CNT_W : ordlt_pkg::POS_W;

  logic [ordlt_pkg::VALUE_W-1:0] mem [CAPACITY];
  logic [ordlt_pkg::VALUE_W-1:0] rdata;

  ordlt_pkg::cmd_t               job;
  logic [CNT_W-1:0]              count;
  logic [CNT_W-1:0]              ptr;
  logic [ordlt_pkg::VALUE_W-1:0] found_value;
  logic [ordlt_pkg::INDEX_W-1:0] found_index;
  logic [1:0]                    outcome;

  logic [CMP_W-1:0]              pos_ext;
  logic [CMP_W-1:0]              count_ext;
  logic [CMP_W-1:0]              ptr_ext;
  logic [CNT_W-1:0]              ptr_up;
  logic [CNT_W-1:0]              ptr_dn;
  logic [ADDR_W-1:0]             raddr;
  logic [ADDR_W-1:0]             waddr;
  logic [ordlt_pkg::VALUE_W-1:0] wdata;

  assign pos_ext   = CMP_W'(job.position);
  assign count_ext = CMP_W'(count);
  assign ptr_ext   = CMP_W'(ptr);
  assign ptr_up    = ptr + 1'b1;
  assign ptr_dn    = ptr - 1'b1;

  assign stat.operation       = job.operation;
  assign stat.full            = (count == CNT_W'(CAPACITY));
  assign stat.pos_le_count    = (pos_ext <= count_ext);
  assign stat.pos_lt_count    = (pos_ext < count_ext);
  assign stat.ptr_gt_pos      = (ptr_ext > pos_ext);
  assign stat.ptr_lt_count    = (ptr < count);
  assign stat.ptr_up_lt_count = (ptr_up < count);
  assign stat.match           = (rdata == job.value);
  assign stat.out_free        = !rsp_valid || rsp_ready;

  always_comb begin
    unique case (ctrl.rd_addr)
      ordlt_pkg::RA_POS:    raddr = pos_ext[ADDR_W-1:0];
      ordlt_pkg::RA_PTR:    raddr = ptr[ADDR_W-1:0];
      ordlt_pkg::RA_PTR_DN: raddr = ptr_dn[ADDR_W-1:0];
      ordlt_pkg::RA_PTR_UP: raddr = ptr_up[ADDR_W-1:0];
      default:              raddr = ptr[ADDR_W-1:0];
    endcase
  end

  always_comb begin
    unique case (ctrl.wr_addr)
      ordlt_pkg::WA_POS:   waddr = pos_ext[ADDR_W-1:0];
      ordlt_pkg::WA_PTR:   waddr = ptr[ADDR_W-1:0];
      ordlt_pkg::WA_COUNT: waddr = count[ADDR_W-1:0];
      default:             waddr = ptr[ADDR_W-1:0];
    endcase
  end

  assign wdata = ctrl.wr_from_mem ? rdata : job.value;

  always_ff @(posedge clk) begin
    if (ctrl.mem_wr) mem[waddr] <= wdata;
    if (ctrl.mem_rd) rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) job <= cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.count_inc) begin
      count <= count + 1'b1;
    end else if (ctrl.count_dec) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctrl.ptr_op)
      ordlt_pkg::PTR_HOLD:  ptr <= ptr;
      ordlt_pkg::PTR_COUNT: ptr <= count;
      ordlt_pkg::PTR_POS:   ptr <= pos_ext[CNT_W-1:0];
      ordlt_pkg::PTR_ZERO:  ptr <= '0;
      ordlt_pkg::PTR_INC:   ptr <= ptr_up;
      ordlt_pkg::PTR_DEC:   ptr <= ptr_dn;
      default:              ptr <= ptr;
    endcase
  end

  // Result fields start at zero with status ok for every new transfer.
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      found_value <= '0;
      found_index <= '0;
      outcome     <= ordlt_pkg::ST_OK;
    end else begin
      if (ctrl.set_status) outcome <= ctrl.status;
      if (ctrl.load_read) found_value <= rdata;
      unique case (ctrl.idx_op)
        ordlt_pkg::IDX_HOLD:  found_index <= found_index;
        ordlt_pkg::IDX_COUNT: found_index <= count_ext[ordlt_pkg::INDEX_W-1:0];
        ordlt_pkg::IDX_PTR:   found_index <= ptr_ext[ordlt_pkg::INDEX_W-1:0];
        default:              found_index <= found_index;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctrl.out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      rsp.read_value   <= found_value;
      rsp.result_index <= found_index;
      rsp.entry_count  <= count_ext[ordlt_pkg::COUNT_W-1:0];
      rsp.status       <= outcome;
    end
  end

endmodule

@@ tb/sv/ordlt_check.sv @@
// Response checker for the ordered list table: watches both channels, keeps its
// own copy of the list, and compares each response with the oldest prediction.
// Depends on ordlt_pkg for the payload structs and the operation/status codes.
`timescale 1ns / 100ps

module ordlt_check
  import ordlt_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  input  logic cmd_ready,
  input  cmd_t cmd,
  input  logic rsp_valid,
  input  logic rsp_ready,
  input  rsp_t rsp,
  output int   fails,
  output int   pending,
  output int   held
);

  logic [VALUE_W-1:0] shadow_list [DEPTH];
  int                 shadow_len;
  rsp_t               due_rsp [$];

  // Applies one command to the shadow list and works out its response.
  task automatic list_apply(input cmd_t c, output rsp_t r);
    int unsigned p;
    int          i;
    p = c.position;
    r = '0;
    r.status = ST_OK;
    case (c.operation)
      OP_APPEND: begin
        if (shadow_len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_list[shadow_len] = c.value;
          r.result_index = shadow_len[INDEX_W-1:0];
          shadow_len++;
        end
      end
      OP_INSERT: begin
        // The position is judged before fullness.
        if (p > shadow_len) begin
          r.status = ST_RANGE;
        end else if (shadow_len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (i = shadow_len; i > int'(p); i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[p] = c.value;
          shadow_len++;
        end
      end
      OP_READ: begin
        if (p >= shadow_len) r.status = ST_RANGE;
        else r.read_value = shadow_list[p];
      end
      OP_WRITE: begin
        if (p >= shadow_len) r.status = ST_RANGE;
        else shadow_list[p] = c.value;
      end
      OP_REMOVE: begin
        if (p >= shadow_len) begin
          r.status = ST_RANGE;
        end else begin
          for (i = p; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i+1];
          shadow_len--;
        end
      end
      OP_FIND: begin
        r.status = ST_NOTFOUND;
        for (i = 0; i < shadow_len; i++) begin
          if (shadow_list[i] == c.value) begin
            r.result_index = i[INDEX_W-1:0];
            r.status = ST_OK;
            break;
          end
        end
      end
      default: begin
      end
    endcase
    r.entry_count = shadow_len[COUNT_W-1:0];
  endtask

  always @(posedge clk) begin
    rsp_t want;
    rsp_t got;
    if (rst) begin
      shadow_len = 0;
      due_rsp.delete();
      fails = 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        got = rsp;
        if (due_rsp.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: response with nothing outstanding: value %h index %0d count %0d status %0d",
                     $realtime, got.read_value, got.result_index, got.entry_count, got.status);
        end else begin
          want = due_rsp.pop_front();
          if (got.read_value !== want.read_value || got.result_index !== want.result_index ||
              got.entry_count !== want.entry_count || got.status !== want.status) begin
            fails++;
            if (fails <= 10)
              $display({"%0t: mismatch: expected value %h index %0d count %0d status %0d,",
                        " got value %h index %0d count %0d status %0d"},
                       $realtime, want.read_value, want.result_index, want.entry_count,
                       want.status, got.read_value, got.result_index, got.entry_count,
                       got.status);
          end
        end
      end
      if (cmd_valid && cmd_ready) begin
        list_apply(cmd, want);
        due_rsp.push_back(want);
      end
    end
    pending = due_rsp.size();
    held = shadow_len;
  end

endmodule

@@ tb/sv/tb.sv @@
// Testbench top for the ordered list table: clock, reset, command stimulus and
// response back-pressure, with the verdict taken from the ordlt_check instance.
// Depends on ordlt_pkg, ordered_list_table and ordlt_check.
`timescale 1ns / 100ps

module tb;
  import ordlt_pkg::*;

  localparam int unsigned DEPTH    = 64;
  localparam int          N_RANDOM = 1850;
  localparam logic [2:0]  OP_SPARE6 = 3'd6;
  localparam logic [2:0]  OP_SPARE7 = 3'd7;

  typedef enum int {MIX_GROW, MIX_EVEN, MIX_SHRINK} mix_e;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  cmd_t cmd = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;
  logic calm = 1'b0;
  int   fails;
  int   pending;
  int   held;

  always #4 clk = ~clk;

  ordered_list_table #(.CAPACITY(DEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  ordlt_check #(.DEPTH(DEPTH)) check (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp),
    .fails    (fails),
    .pending  (pending),
    .held     (held)
  );

  always @(negedge clk) begin
    rsp_ready <= calm || ($urandom_range(99) >= 35);
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  // Valid is only lowered when an idle gap follows, so it never drops and
  // rises within one step.
  task automatic send_cmd(input logic [2:0] op, input logic [POS_W-1:0] pos,
                          input logic [VALUE_W-1:0] val);
    if (!calm && $urandom_range(99) < 35) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < 35) @(negedge clk);
    end
    cmd       <= '{operation: op, position: pos, value: val};
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_cmd(input mix_e mix);
    int               r;
    int               lim;
    logic [2:0]       op;
    logic [POS_W-1:0] pos;
    logic [VALUE_W-1:0] val;
    r = $urandom_range(99);
    case (mix)
      MIX_GROW: begin
        op = r < 35 ? OP_APPEND : r < 70 ? OP_INSERT : r < 78 ? OP_READ :
             r < 86 ? OP_WRITE : r < 94 ? OP_FIND : r < 98 ? OP_REMOVE : OP_SPARE6;
      end
      MIX_EVEN: begin
        op = r < 17 ? OP_APPEND : r < 34 ? OP_INSERT : r < 50 ? OP_READ :
             r < 66 ? OP_WRITE : r < 82 ? OP_FIND : r < 98 ? OP_REMOVE : OP_SPARE6;
      end
      default: begin
        op = r < 8 ? OP_APPEND : r < 16 ? OP_INSERT : r < 30 ? OP_READ :
             r < 44 ? OP_WRITE : r < 58 ? OP_FIND : r < 96 ? OP_REMOVE : OP_SPARE6;
      end
    endcase
    if (op == OP_SPARE6 && $urandom_range(1)) op = OP_SPARE7;

    // Mostly legal positions, with the boundaries and the whole field mixed in.
    lim = (op == OP_INSERT) ? held : held - 1;
    if (lim < 0) lim = 0;
    case ($urandom_range(9))
      0:       pos = '0;
      1:       pos = held[POS_W-1:0];
      2:       pos = held > 0 ? POS_W'(held - 1) : '0;
      3:       pos = POS_W'($urandom_range(127));
      default: pos = POS_W'($urandom_range(lim));
    endcase

    // Small values repeat often, so finds hit and duplicates test the first match.
    case ($urandom_range(9))
      0, 1, 2, 3: val = VALUE_W'($urandom_range(15));
      4:          val = '1;
      5:          val = '0;
      default:    val = {$urandom, $urandom};
    endcase
    send_cmd(op, pos, val);
  endtask

  initial begin
    mix_e mix;
    rst = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part: the empty list, the boundaries of each position check,
    // duplicates for find, and the unused operation codes.
    send_cmd(OP_READ,   7'd0,   64'd0);
    send_cmd(OP_REMOVE, 7'd0,   64'd0);
    send_cmd(OP_WRITE,  7'd0,   64'h1);
    send_cmd(OP_FIND,   7'd0,   64'd0);
    send_cmd(OP_INSERT, 7'd1,   64'h2);
    send_cmd(OP_INSERT, 7'd127, 64'h3);
    send_cmd(OP_INSERT, 7'd0,   '1);
    send_cmd(OP_APPEND, 7'd127, 64'd0);
    send_cmd(OP_APPEND, 7'd0,   64'h5555_5555_5555_5555);
    send_cmd(OP_INSERT, 7'd3,   64'hAAAA_AAAA_AAAA_AAAA);
    send_cmd(OP_INSERT, 7'd1,   64'h0123_4567_89AB_CDEF);
    send_cmd(OP_READ,   7'd0,   64'd0);
    send_cmd(OP_READ,   7'd4,   64'd0);
    send_cmd(OP_READ,   7'd5,   64'd0);
    send_cmd(OP_WRITE,  7'd2,   '1);
    send_cmd(OP_FIND,   7'd0,   '1);
    send_cmd(OP_FIND,   7'd0,   64'hDEAD_BEEF_0000_0001);
    send_cmd(OP_WRITE,  7'd5,   64'h7);
    send_cmd(OP_REMOVE, 7'd4,   64'd0);
    send_cmd(OP_REMOVE, 7'd0,   64'd0);
    send_cmd(OP_SPARE6, 7'd127, '1);
    send_cmd(OP_SPARE7, 7'd64,  64'h8000_0000_0000_0000);
    send_cmd(OP_READ,   7'd64,  64'd0);
    send_cmd(OP_REMOVE, 7'd127, 64'd0);
    send_cmd(OP_FIND,   7'd0,   64'd0);

    // Random part: phases that fill the list to the top, churn it and drain it.
    for (int n = 0; n < N_RANDOM; n++) begin
      case ((n / 150) % 4)
        0:       mix = MIX_GROW;
        1:       mix = MIX_EVEN;
        2:       mix = MIX_SHRINK;
        default: mix = MIX_EVEN;
      endcase
      calm <= (n >= 600 && n < 900);
      random_cmd(mix);
    end
    cmd_valid <= 1'b0;
    calm <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
